>>> sv/oal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_pkg: shared types and constants for the ordered array list
// Sizes, operation and status codes, controller state and command struct.
// ----------------------------------------------------------------------------
package oal_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;

    // fixed field widths of the request and response
    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND    = 3'd0,
        CMD_READ      = 3'd1,
        CMD_OVERWRITE = 3'd2,
        CMD_INSERT    = 3'd3,
        CMD_REMOVE    = 3'd4
    } cmd_e;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_e;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;    // capture the accepted request
        logic exec;    // perform the operation and fill the response register
    } ctrl_cmd_t;

endpackage

>>> sv/oal_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_req_if / oal_rsp_if: request and response channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface oal_req_if;
    import oal_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] entry_value;

    modport source (output valid, output cmd, output position, output entry_value,
                    input ready);
    modport sink   (input valid, input cmd, input position, input entry_value,
                    output ready);
endinterface

interface oal_rsp_if;
    import oal_pkg::*;

    logic               valid;
    logic               ready;
    logic [DATA_W-1:0]  read_value;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output read_value, output status, output count,
                    input ready);
    modport sink   (input valid, input read_value, input status, input count,
                    output ready);
endinterface

>>> sv/oal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_ctrl: request sequencer
// Takes a request when the response register is free, then runs the execute
// state and raises response valid until the response is taken.
// ----------------------------------------------------------------------------
module oal_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output oal_pkg::ctrl_cmd_t ctrl
);
    import oal_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        ctrl           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                // response register frees up at this edge if it is taken now
                in_ready = !out_valid_reg || out_ready;
                if (in_valid && in_ready)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                ctrl.exec      = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

>>> sv/oal_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oal_datapath: entry chain, count and response register
// Entries sit in a register chain that shifts up or down in a single update for
// insert and remove; range and full checks gate every update.
// ----------------------------------------------------------------------------
module oal_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  oal_pkg::ctrl_cmd_t          ctrl,
    input  logic [oal_pkg::CMD_W-1:0]   cmd,
    input  logic [oal_pkg::POS_W-1:0]   position,
    input  logic [oal_pkg::DATA_W-1:0]  entry_value,
    output logic [oal_pkg::DATA_W-1:0]  read_value,
    output logic [oal_pkg::STAT_W-1:0]  status,
    output logic [oal_pkg::COUNT_W-1:0] count
);
    import oal_pkg::*;

    logic [CMD_W-1:0]       cmd_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;

    logic [VALUE_WIDTH-1:0] entries_reg  [DEPTH];
    logic [VALUE_WIDTH-1:0] entries_next [DEPTH];
    logic [VALUE_WIDTH-1:0] up_src       [DEPTH];
    logic [VALUE_WIDTH-1:0] dn_src       [DEPTH];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    logic [DATA_W-1:0]      rd_reg;
    logic [DATA_W-1:0]      rd_next;
    logic [STAT_W-1:0]      stat_reg;
    logic [STAT_W-1:0]      stat_next;
    logic [COUNT_W-1:0]     cnt_out_reg;

    logic [CMP_W-1:0]       pos_x;
    logic [CMP_W-1:0]       cnt_x;
    logic                   full;
    logic                   pos_lt_cnt;
    logic                   pos_le_cnt;

    // neighbor taps for the parallel shift
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_taps
        if (g == 0)
        begin : g_first
            assign up_src[g] = entries_reg[g];
        end
        else
        begin : g_up
            assign up_src[g] = entries_reg[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign dn_src[g] = entries_reg[g];
        end
        else
        begin : g_dn
            assign dn_src[g] = entries_reg[g+1];
        end
    end

    assign pos_x      = CMP_W'(pos_reg);
    assign cnt_x      = CMP_W'(count_reg);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign pos_lt_cnt = (pos_x < cnt_x);
    assign pos_le_cnt = (pos_x <= cnt_x);

    always_comb
    begin
        entries_next = entries_reg;
        count_next   = count_reg;
        rd_next      = '0;
        stat_next    = STAT_OK;
        unique case (cmd_reg)
            CMD_APPEND:
            begin
                if (full)
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (CMP_W'(i) == cnt_x)
                        begin
                            entries_next[i] = val_reg;
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_READ:
            begin
                if (!pos_lt_cnt)
                begin
                    stat_next = STAT_RANGE;
                end
                else
                begin
                    rd_next = DATA_W'(entries_reg[pos_x[IDX_W-1:0]]);
                end
            end
            CMD_OVERWRITE:
            begin
                if (!pos_lt_cnt)
                begin
                    stat_next = STAT_RANGE;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (CMP_W'(i) == pos_x)
                        begin
                            entries_next[i] = val_reg;
                        end
                    end
                end
            end
            CMD_INSERT:
            begin
                // range check takes precedence over full
                if (!pos_le_cnt)
                begin
                    stat_next = STAT_RANGE;
                end
                else if (full)
                begin
                    stat_next = STAT_FULL;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (CMP_W'(i) == pos_x)
                        begin
                            entries_next[i] = val_reg;
                        end
                        else if (CMP_W'(i) > pos_x && CMP_W'(i) <= cnt_x)
                        begin
                            entries_next[i] = up_src[i];
                        end
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (!pos_lt_cnt)
                begin
                    stat_next = STAT_RANGE;
                end
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                    begin
                        if (CMP_W'(i) >= pos_x && CMP_W'(i + 1) < cnt_x)
                        begin
                            entries_next[i] = dn_src[i];
                        end
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                // unused codes: no change, ok status
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.exec)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            pos_reg <= position;
            val_reg <= VALUE_WIDTH'(entry_value);
        end
        if (ctrl.exec)
        begin
            entries_reg <= entries_next;
            rd_reg      <= rd_next;
            stat_reg    <= stat_next;
            cnt_out_reg <= COUNT_W'(count_next);
        end
    end

    assign read_value = rd_reg;
    assign status     = stat_reg;
    assign count      = cnt_out_reg;

endmodule

>>> sv/ordered_array_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_core: fixed-capacity ordered list
// Append, read, overwrite, insert and remove on a list of up to DEPTH entries.
// ----------------------------------------------------------------------------
//  channel | dir | fields                          | transfer
//  --------+-----+---------------------------------+-------------------------
//  req     | in  | cmd, position, entry_value      | req.valid && req.ready
//  rsp     | out | read_value, status, count       | rsp.valid && rsp.ready
//
//  Each request is first captured, then the entry chain is updated and the
//  response register loaded in the execute state. Insert and remove shift the
//  whole chain in that single update.
//  A new request is taken in the cycle its predecessor's response is taken.
//  Reset clears the count and the handshake state; entries are not cleared.
//  A stalled response holds its value until taken.
// ----------------------------------------------------------------------------
module ordered_array_list_core (
    input  logic      clk,
    input  logic      rst_n,
    oal_req_if.sink   req,
    oal_rsp_if.source rsp
);
    import oal_pkg::*;

    ctrl_cmd_t ctrl;

    oal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    oal_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .cmd         (req.cmd),
        .position    (req.position),
        .entry_value (req.entry_value),
        .read_value  (rsp.read_value),
        .status      (rsp.status),
        .count       (rsp.count)
    );

endmodule

>>> verif/ordered_array_list_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_array_list_core_tb: self-checking bench for the ordered array list
// Drives append/read/overwrite/insert/remove requests, first from a directed
// table and then at random, mirrors the list in a local model and checks each
// response field by field; source and sink stall at random except in the last pass.
// ----------------------------------------------------------------------------
module ordered_array_list_core_tb;
    import oal_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_PASS = 630;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct packed {
        logic [DATA_W-1:0]  read_value;
        status_e            status;
        logic [COUNT_W-1:0] count;
    } list_result_t;

    typedef struct packed {
        cmd_e               op;
        logic [POS_W-1:0]   pos;
        logic [DATA_W-1:0]  value;
        int                 reps;
        bit                 typed;
        logic [DATA_W-1:0]  exp_read;
        status_e            exp_status;
        logic [COUNT_W-1:0] exp_count;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    oal_req_if req_ch ();
    oal_rsp_if rsp_ch ();

    ordered_array_list_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #1 clk = ~clk;

    // local copy of the list
    logic [VALUE_WIDTH-1:0] held [DEPTH];
    int                     held_count = 0;

    list_result_t pending_results [$];
    int           mismatches = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           hold_req = 0;
    bit           filling = 1'b1;

    script_row_t script [25] = '{
        '{CMD_READ,      5'd0,  32'h0000_0000, 1,  1'b1, 32'h0, STAT_RANGE, 5'd0},
        '{CMD_REMOVE,    5'd0,  32'h0000_0000, 1,  1'b1, 32'h0, STAT_RANGE, 5'd0},
        '{CMD_OVERWRITE, 5'd0,  32'h0000_0001, 1,  1'b1, 32'h0, STAT_RANGE, 5'd0},
        '{CMD_INSERT,    5'd1,  32'h0000_0002, 1,  1'b1, 32'h0, STAT_RANGE, 5'd0},
        '{CMD_INSERT,    5'd0,  32'hFFFF_FFFF, 1,  1'b1, 32'h0, STAT_OK,    5'd1},
        // position is don't-care for append
        '{CMD_APPEND,    5'd16, 32'h0000_0000, 1,  1'b1, 32'h0, STAT_OK,    5'd2},
        '{CMD_READ,      5'd0,  32'h0000_0000, 1,  1'b1, 32'hFFFF_FFFF, STAT_OK, 5'd2},
        '{CMD_READ,      5'd1,  32'h0000_0000, 1,  1'b1, 32'h0, STAT_OK,    5'd2},
        '{CMD_INSERT,    5'd1,  32'hA5A5_5A5A, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        // insert at the end behaves as append
        '{CMD_INSERT,    5'd3,  32'h0000_1234, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_OVERWRITE, 5'd0,  32'h0000_0000, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_READ,      5'd2,  32'h0000_0000, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_REMOVE,    5'd0,  32'h0000_0000, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_REMOVE,    5'd2,  32'h0000_0000, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_APPEND,    5'd0,  32'h5555_AAAA, 14, 1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_APPEND,    5'd0,  32'hDEAD_BEEF, 1,  1'b1, 32'h0, STAT_FULL,  5'd16},
        '{CMD_INSERT,    5'd16, 32'h0000_0003, 1,  1'b1, 32'h0, STAT_FULL,  5'd16},
        '{CMD_INSERT,    5'd0,  32'h0000_0004, 1,  1'b1, 32'h0, STAT_FULL,  5'd16},
        '{CMD_READ,      5'd16, 32'h0000_0000, 1,  1'b1, 32'h0, STAT_RANGE, 5'd16},
        '{CMD_READ,      5'd15, 32'h0000_0000, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_OVERWRITE, 5'd15, 32'hFFFF_FFFF, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_REMOVE,    5'd15, 32'h0000_0000, 1,  1'b0, 32'h0, STAT_OK,    5'd0},
        // insert past the end is out of range
        '{CMD_INSERT,    5'd16, 32'h0000_0005, 1,  1'b1, 32'h0, STAT_RANGE, 5'd15},
        '{CMD_REMOVE,    5'd0,  32'h0000_0000, 15, 1'b0, 32'h0, STAT_OK,    5'd0},
        '{CMD_REMOVE,    5'd0,  32'h0000_0000, 1,  1'b1, 32'h0, STAT_RANGE, 5'd0}
    };

    function automatic list_result_t list_apply(cmd_e op, logic [POS_W-1:0] pos,
                                                logic [DATA_W-1:0] value);
        list_result_t r;
        int           p;
        int           i;
        r.read_value = '0;
        r.status     = STAT_OK;
        p            = int'(pos);
        case (op)
            CMD_APPEND:
                if (held_count >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    held[held_count] = value;
                    held_count++;
                end
            CMD_READ:
                if (p >= held_count)
                    r.status = STAT_RANGE;
                else
                    r.read_value = held[p];
            CMD_OVERWRITE:
                if (p >= held_count)
                    r.status = STAT_RANGE;
                else
                    held[p] = value;
            CMD_INSERT:
                if (p > held_count)
                    r.status = STAT_RANGE;
                else if (held_count >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    for (i = held_count; i > p; i--)
                        held[i] = held[i-1];
                    held[p] = value;
                    held_count++;
                end
            CMD_REMOVE:
                if (p >= held_count)
                    r.status = STAT_RANGE;
                else
                begin
                    for (i = p; i + 1 < held_count; i++)
                        held[i] = held[i+1];
                    held_count--;
                end
            default:
                ;
        endcase
        r.count = held_count[COUNT_W-1:0];
        return r;
    endfunction

    // Offer one request, wait for its transfer, then queue the expected response.
    task automatic send_request(cmd_e op, logic [POS_W-1:0] pos, logic [DATA_W-1:0] value,
                                bit typed, list_result_t typed_res);
        list_result_t res;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= op;
        req_ch.position    <= pos;
        req_ch.entry_value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        res = list_apply(op, pos, value);
        if (typed)
            res = typed_res;
        pending_results.push_back(res);
    endtask

    // response sink: random stalls plus a single long hold-off
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // response checker
    initial
    begin
        list_result_t exp_res;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected response transfer: read_value %h status %0d count %0d",
                           rsp_ch.read_value, rsp_ch.status, rsp_ch.count);
                    mismatches++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (rsp_ch.read_value !== exp_res.read_value)
                    begin
                        $error("read_value: expected %h, got %h",
                               exp_res.read_value, rsp_ch.read_value);
                        mismatches++;
                    end
                    if (rsp_ch.status !== exp_res.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_res.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.count !== exp_res.count)
                    begin
                        $error("count: expected %0d, got %0d", exp_res.count, rsp_ch.count);
                        mismatches++;
                    end
                end
            end
        end
    end

    // watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int                tx_pct [3];
        int                rx_pct [3];
        int                row;
        int                rep;
        int                pass;
        int                n;
        int                roll;
        cmd_e              op;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
        list_result_t      typed_res;

        tx_pct = '{35, 49, 0};
        rx_pct = '{49, 35, 0};

        req_ch.valid       = 1'b0;
        req_ch.cmd         = CMD_APPEND;
        req_ch.position    = '0;
        req_ch.entry_value = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = tx_pct[0];
        rx_idle_pct = rx_pct[0];
        for (row = 0; row < $size(script); row++)
        begin
            typed_res.read_value = script[row].exp_read;
            typed_res.status     = script[row].exp_status;
            typed_res.count      = script[row].exp_count;
            for (rep = 0; rep < script[row].reps; rep++)
                send_request(script[row].op, script[row].pos, script[row].value,
                             script[row].typed, typed_res);
        end

        for (pass = 0; pass < 3; pass++)
        begin
            tx_idle_pct = tx_pct[pass];
            rx_idle_pct = rx_pct[pass];
            for (n = 0; n < ITEMS_PER_PASS; n++)
            begin
                // sink goes quiet while requests keep coming
                if (pass == 0 && n == 200)
                    hold_req <= hold_req + 1;

                if (held_count == DEPTH)
                    filling = 1'b0;
                else if (held_count == 0)
                    filling = 1'b1;
                else if ($urandom_range(0, 99) < 2)
                    filling = ~filling;

                roll = $urandom_range(0, 99);
                if (filling)
                    op = (roll < 30) ? CMD_APPEND : (roll < 55) ? CMD_INSERT :
                         (roll < 75) ? CMD_READ : (roll < 90) ? CMD_OVERWRITE : CMD_REMOVE;
                else
                    op = (roll < 10) ? CMD_APPEND : (roll < 20) ? CMD_INSERT :
                         (roll < 40) ? CMD_READ : (roll < 55) ? CMD_OVERWRITE : CMD_REMOVE;

                if ($urandom_range(0, 99) < 15)
                    pos = POS_W'($urandom_range(0, DEPTH));
                else if (op == CMD_INSERT)
                    pos = POS_W'($urandom_range(0, held_count));
                else if (held_count == 0)
                    pos = '0;
                else
                    pos = POS_W'($urandom_range(0, held_count - 1));

                roll = $urandom_range(0, 9);
                value = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;

                send_request(op, pos, value, 1'b0, typed_res);
            end

            // pause the source until every response is back
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while (pending_results.size() != 0);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/oal_pkg.sv
sv/oal_if.sv
sv/oal_ctrl.sv
sv/oal_datapath.sv
sv/ordered_array_list_core.sv
verif/ordered_array_list_core_tb.sv
